@@ hw/rtl/response_frame_receiver_crc16_assert.svh @@
// Assertion macros shared by the receiver modules.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef RESPONSE_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define RESPONSE_FRAME_RECEIVER_CRC16_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

// The expression must never be true.
`define RFR_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/rfr_pkg.sv @@
// ----------------------------------------------------------------------------
// rfr_pkg
// Types, codes and the CRC-16 step shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package rfr_pkg;

  localparam logic [15:0] CrcPoly        = 16'h8408;
  localparam logic [7:0]  SyncByte       = 8'h02;
  localparam logic [7:0]  CodeIllegal    = 8'h30;
  localparam logic [7:0]  CodeNak        = 8'hFF;
  localparam logic [7:0]  CodeAck        = 8'h00;
  localparam logic [7:0]  MinTotalLength = 8'd6;
  localparam logic [7:0]  FrameOverhead  = 8'd5;
  localparam logic [7:0]  OwnAddrReset   = 8'd3;

  // Queue between parser and output stage
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // Output beat kind (travels on tuser)
  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  typedef enum logic [2:0] {
    PH_SYNC    = 3'd0,
    PH_ADDR    = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC_LO  = 3'd4,
    PH_CRC_HI  = 3'd5
  } rfr_phase_e;

  typedef enum logic [2:0] {
    ST_DATA     = 3'd0,
    ST_ACK      = 3'd1,
    ST_NAK      = 3'd2,
    ST_ILLEGAL  = 3'd3,
    ST_CRC_ERR  = 3'd4,
    ST_ADDR_ERR = 3'd5,
    ST_BAD_SYNC = 3'd6,
    ST_BAD_LEN  = 3'd7
  } rfr_status_e;

  typedef enum logic [1:0] {
    RP_NONE = 2'd0,
    RP_ACK  = 2'd1,
    RP_NAK  = 2'd2
  } rfr_reply_e;

  // One classified event from the parser
  typedef struct packed {
    logic        kind;
    rfr_status_e status;
    logic [7:0]  data;
    logic [7:0]  index;
    logic [7:0]  addr;
    logic [7:0]  plen;
  } rfr_rec_t;

  // Reflected CRC-16 update over one byte, one bit per step
  function automatic logic [15:0] rfr_crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/rfr_front.sv @@
// ----------------------------------------------------------------------------
// rfr_front
// Frame parser: accepts received bytes, tracks the frame, runs the CRC and
// classifies each byte into at most one event for the queue.
// ----------------------------------------------------------------------------
module rfr_front import rfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  output logic       in_ready_o,
  input  logic       q_full_i,
  output logic       push_o,
  output rfr_rec_t   push_rec_o
);

  rfr_phase_e  phase_q, phase_d;
  logic [7:0]  own_addr_q;
  logic [7:0]  addr_q, addr_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  first_q, first_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic        accept;
  logic        has_rec;
  rfr_rec_t    rec;
  logic [15:0] crc_upd;
  logic [7:0]  cnt_inc;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign crc_upd    = rfr_crc_step(crc_q, in_byte_i);
  assign cnt_inc    = cnt_q + 8'd1;

  // Hold the device address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= OwnAddrReset;
    end else if (cfg_we_i) begin
      own_addr_q <= cfg_wdata_i;
    end
  end

  // Classify the byte and work out the next frame state
  always_comb begin
    phase_d  = phase_q;
    addr_d   = addr_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    first_d  = first_q;
    crc_lo_d = crc_lo_q;
    has_rec  = 1'b0;
    rec      = '{kind: KindStatus, status: ST_DATA, data: 8'h00, index: 8'h00,
                 addr: addr_q, plen: cnt_q};
    case (phase_q)
      PH_ADDR: begin
        addr_d  = in_byte_i;
        crc_d   = crc_upd;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        len_d = in_byte_i;
        crc_d = crc_upd;
        cnt_d = 8'd0;
        if (in_byte_i < MinTotalLength) begin
          phase_d    = PH_SYNC;
          has_rec    = 1'b1;
          rec.status = ST_BAD_LEN;
          rec.plen   = 8'd0;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_d = crc_upd;
        if (cnt_q == 8'd0) begin
          first_d = in_byte_i;
        end
        has_rec   = 1'b1;
        rec.kind  = KindPayload;
        rec.data  = in_byte_i;
        rec.index = cnt_q;
        cnt_d     = cnt_inc;
        if (cnt_inc >= (len_q - FrameOverhead)) begin
          phase_d = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        crc_lo_d = in_byte_i;
        phase_d  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        phase_d = PH_SYNC;
        has_rec = 1'b1;
        if ({in_byte_i, crc_lo_q} != crc_q) begin
          rec.status = ST_CRC_ERR;
        end else if (addr_q != own_addr_q) begin
          rec.status = ST_ADDR_ERR;
        end else if (cnt_q == 8'd1 && first_q == CodeIllegal) begin
          rec.status = ST_ILLEGAL;
        end else if (cnt_q == 8'd1 && first_q == CodeNak) begin
          rec.status = ST_NAK;
        end else if (cnt_q == 8'd1 && first_q == CodeAck) begin
          rec.status = ST_ACK;
        end else begin
          rec.status = ST_DATA;
        end
      end
      default: begin
        phase_d = PH_SYNC;
        if (in_byte_i != SyncByte) begin
          has_rec    = 1'b1;
          rec.status = ST_BAD_SYNC;
          rec.addr   = 8'd0;
          rec.plen   = 8'd0;
        end else begin
          crc_d   = rfr_crc_step(16'h0000, in_byte_i);
          cnt_d   = 8'd0;
          phase_d = PH_ADDR;
        end
      end
    endcase
  end

  assign push_o     = accept && has_rec;
  assign push_rec_o = rec;

  // Advance the frame state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SYNC;
      addr_q   <= 8'd0;
      len_q    <= 8'd0;
      cnt_q    <= 8'd0;
      crc_q    <= 16'h0000;
      first_q  <= 8'd0;
      crc_lo_q <= 8'd0;
    end else if (accept) begin
      phase_q  <= phase_d;
      addr_q   <= addr_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      crc_q    <= crc_d;
      first_q  <= first_d;
      crc_lo_q <= crc_lo_d;
    end
  end

`include "response_frame_receiver_crc16_assert.svh"

  // A frame always closes with a status event and a return to sync
  `RFR_ASSERT_NEXT(a_crc_hi_closes, accept && phase_q == PH_CRC_HI, phase_q == PH_SYNC)
  `RFR_ASSERT_IMPL(a_crc_hi_pushes, accept && phase_q == PH_CRC_HI, push_o)

endmodule

@@ hw/rtl/rfr_fifo.sv @@
// ----------------------------------------------------------------------------
// rfr_fifo
// Short event queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module rfr_fifo import rfr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  rfr_rec_t push_rec_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output rfr_rec_t pop_rec_o
);

  rfr_rec_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]     count_q, count_d;
  logic                   do_push, do_pop;

  assign full_o    = (count_q == (QueuePtrW + 1)'(QueueDepth));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_rec_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  // Write the entry at the tail
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

`include "response_frame_receiver_crc16_assert.svh"

  `RFR_ASSERT_NEVER(a_count_range, count_q > (QueuePtrW + 1)'(QueueDepth))
  `RFR_ASSERT_NEVER(a_push_full, push_i && full_o)
  `RFR_ASSERT_NEXT(a_push_counts, do_push && !do_pop, count_q == $past(count_q) + 1'b1)

endmodule

@@ hw/rtl/rfr_back.sv @@
// ----------------------------------------------------------------------------
// rfr_back
// Output stage: drains the event queue, decodes the reply request and
// holds the result beat in a register until it is taken.
// ----------------------------------------------------------------------------
module rfr_back import rfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  rfr_rec_t    rec_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [39:0] out_data_o,
  output logic        out_user_o
);

  logic        valid_q;
  logic [39:0] data_q, data_d;
  logic        user_q;
  logic        load;
  rfr_reply_e  reply;
  logic [7:0]  data_byte, index;
  logic [2:0]  status;
  logic [7:0]  addr, plen;

  assign load  = !empty_i && (!valid_q || out_ready_i);
  assign pop_o = load;

  // Decode the reply and clear fields that do not apply to the beat kind
  always_comb begin
    reply     = RP_NONE;
    data_byte = rec_i.data;
    index     = rec_i.index;
    status    = 3'd0;
    addr      = 8'd0;
    plen      = 8'd0;
    if (rec_i.kind == KindStatus) begin
      data_byte = 8'd0;
      index     = 8'd0;
      status    = rec_i.status;
      addr      = rec_i.addr;
      plen      = rec_i.plen;
      case (rec_i.status)
        ST_CRC_ERR: reply = RP_NAK;
        ST_DATA:    reply = RP_ACK;
        default:    reply = RP_NONE;
      endcase
    end
    data_d = {3'b000, reply, plen, addr, status, index, data_byte};
  end

  // Hold the beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
      user_q <= rec_i.kind;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_user_o  = user_q;

endmodule

@@ hw/rtl/response_frame_receiver_crc16.sv @@
// ----------------------------------------------------------------------------
// response_frame_receiver_crc16
// Receiver for CRC-16 checked response frames with payload pass-through.
// ----------------------------------------------------------------------------
// Input stream: one received serial byte per beat on s_axis_tdata.
// Output stream: one beat per payload byte (tuser 0) and one status beat at
// the end of each frame or for each rejected byte (tuser 1). Bytes that only
// advance the frame (sync, address, a valid length, CRC low) give no beat.
// Frame: 0x02, address, total length, payload (length - 5 bytes), CRC low,
// CRC high; reflected CRC-16 0x8408, init 0, over all bytes before the CRC.
// With the queue empty, each beat is written into the event queue and then
// loaded into the output register, which presents it on m_axis.
// Throughput: one byte per cycle; the parser and its CRC step take a byte
// every cycle, limited only by the four-entry event queue filling.
// When m_axis_tready is held low the output register holds its beat, the
// queue fills, and s_axis_tready falls once the queue is full.
// Reset clears the parser to waiting for sync, empties the queue and sets
// the device address register to 3. cfg_we_i writes the address directly.
// ----------------------------------------------------------------------------
module response_frame_receiver_crc16 import rfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] data_byte, [15:8] payload_index, [18:16] status,
  // [26:19] frame_address, [34:27] payload_length, [36:35] reply, [39:37] zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tuser    // [0] kind
);

  logic     q_full, q_empty, push, pop;
  rfr_rec_t push_rec, pop_rec;

  rfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_byte_i   (s_axis_tdata),
    .in_ready_o  (s_axis_tready),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_rec_o  (push_rec)
  );

  rfr_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .pop_rec_o  (pop_rec)
  );

  rfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .rec_i       (pop_rec),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

@@ bench/tb_response_frame_receiver_crc16.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_response_frame_receiver_crc16
// Self-checking bench for the CRC-16 response frame receiver.
// ----------------------------------------------------------------------------
// Feeds serial bytes on the input stream: directed frames covering every
// status first, then random traffic that is mostly well-formed frames with
// random content, mixed with noise, short lengths and truncated frames. A
// behavioural model of the parser predicts every output beat; each beat on
// the output stream is checked field by field against the oldest prediction.
// The sender runs in random bursts and the receiver stalls in shifting
// patterns. The device address is changed between phases, with the bench idle.
// ----------------------------------------------------------------------------
module tb_response_frame_receiver_crc16;
  import rfr_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned SettleBeats = 12;
  localparam int unsigned PhaseBytes  = 150;

  typedef logic [7:0] byte_q_t[$];

  // One predicted output beat
  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [7:0]  index;
    rfr_status_e status;
    logic [7:0]  addr;
    logic [7:0]  plen;
    rfr_reply_e  reply;
  } rx_beat_t;

  // Parser model and store of the beats it predicts
  class frame_checker;
    logic [7:0]  own_addr;
    rfr_phase_e  phase;
    logic [7:0]  cap_addr;
    logic [7:0]  cap_len;
    logic [7:0]  count;
    logic [15:0] crc;
    logic [7:0]  first_byte;
    logic [7:0]  crc_lo;
    rx_beat_t    pending_beats[$];
    int unsigned errors;

    function new();
      own_addr   = OwnAddrReset;
      phase      = PH_SYNC;
      cap_addr   = '0;
      cap_len    = '0;
      count      = '0;
      crc        = '0;
      first_byte = '0;
      crc_lo     = '0;
      errors     = 0;
    endfunction

    // Reflected CRC-16 over one byte, polynomial 0x8408
    static function logic [15:0] crc16_step(logic [15:0] c_in, logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
        c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
    endfunction

    // Advance the parser by one accepted byte and queue any beat it causes
    function void take_byte(logic [7:0] b);
      rx_beat_t   e;
      bit         emit;
      logic [7:0] goal;
      e    = '0;
      emit = 1'b0;
      case (phase)
        PH_ADDR: begin
          cap_addr = b;
          crc      = crc16_step(crc, b);
          phase    = PH_LEN;
        end
        PH_LEN: begin
          cap_len = b;
          crc     = crc16_step(crc, b);
          count   = '0;
          if (b < MinTotalLength) begin
            phase    = PH_SYNC;
            e.kind   = KindStatus;
            e.status = ST_BAD_LEN;
            e.addr   = cap_addr;
            e.reply  = RP_NONE;
            emit     = 1'b1;
          end else begin
            phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          crc = crc16_step(crc, b);
          if (count == 0) first_byte = b;
          e.kind  = KindPayload;
          e.data  = b;
          e.index = count;
          emit    = 1'b1;
          count   = count + 8'd1;
          goal    = cap_len - FrameOverhead;
          if (count >= goal) phase = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          crc_lo = b;
          phase  = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          phase  = PH_SYNC;
          e.kind = KindStatus;
          e.addr = cap_addr;
          e.plen = count;
          emit   = 1'b1;
          // CRC is judged first, then address, then one-byte commands
          if ({b, crc_lo} != crc) begin
            e.status = ST_CRC_ERR;
            e.reply  = RP_NAK;
          end else if (cap_addr != own_addr) begin
            e.status = ST_ADDR_ERR;
            e.reply  = RP_NONE;
          end else if (count == 8'd1 && first_byte == CodeIllegal) begin
            e.status = ST_ILLEGAL;
            e.reply  = RP_NONE;
          end else if (count == 8'd1 && first_byte == CodeNak) begin
            e.status = ST_NAK;
            e.reply  = RP_NONE;
          end else if (count == 8'd1 && first_byte == CodeAck) begin
            e.status = ST_ACK;
            e.reply  = RP_NONE;
          end else begin
            e.status = ST_DATA;
            e.reply  = RP_ACK;
          end
        end
        default: begin
          phase = PH_SYNC;
          if (b != SyncByte) begin
            e.kind   = KindStatus;
            e.status = ST_BAD_SYNC;
            e.reply  = RP_NONE;
            emit     = 1'b1;
          end else begin
            crc   = crc16_step(16'h0000, b);
            count = '0;
            phase = PH_ADDR;
          end
        end
      endcase
      if (emit) pending_beats = {pending_beats, e};
    endfunction

    function void match(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    // Compare one output beat with the oldest prediction
    function void check_beat(logic [39:0] d, logic kind);
      rx_beat_t e;
      if (pending_beats.size() == 0) begin
        $error("beat with nothing expected: tdata %h tuser %b", d, kind);
        errors++;
        return;
      end
      e = pending_beats.pop_front();
      match("kind",           {7'd0, e.kind},  {7'd0, kind});
      match("data_byte",      e.data,          d[7:0]);
      match("payload_index",  e.index,         d[15:8]);
      match("status",         {5'd0, e.status}, {5'd0, d[18:16]});
      match("frame_address",  e.addr,          d[26:19]);
      match("payload_length", e.plen,          d[34:27]);
      match("reply",          {6'd0, e.reply}, {6'd0, d[36:35]});
      match("padding",        8'd0,            {5'd0, d[39:37]});
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;

  frame_checker board;
  int unsigned  burst_left;
  int unsigned  bytes_sent;
  int unsigned  cycle_count;
  int unsigned  ready_mode;
  int unsigned  mode_left;
  logic [15:0]  ready_pattern;

  response_frame_receiver_crc16 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver back-pressure: switch to a new random stall pattern whenever the current mode runs out
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode    = $urandom_range(4);
      mode_left     = $urandom_range(20, 300);
      ready_pattern = 16'($urandom);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(3) != 0);
      2:       m_axis_tready <= ($urandom_range(9) < 3);
      3: begin
        m_axis_tready <= ready_pattern[0];
        ready_pattern  = {ready_pattern[0], ready_pattern[15:1]};
      end
      default: m_axis_tready <= (cycle_count % 16 == 0);
    endcase
  end

  // Check every beat taken from the output stream
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_beat(m_axis_tdata, m_axis_tuser);
    end
  end

  // Offer one byte, inserting a random gap whenever a burst runs out
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(60, 150)
                                            : $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.take_byte(b);
    bytes_sent++;
  endtask

  // Build a frame with its CRC; send only the first keep bytes of it
  task automatic send_frame(input logic [7:0] addr, input byte_q_t payload,
                            input bit spoil, input int unsigned keep);
    logic [7:0]  wire_bytes[$];
    logic [15:0] crc;
    logic [7:0]  total;
    total      = 8'(payload.size()) + FrameOverhead;
    wire_bytes = {SyncByte, addr, total};
    foreach (payload[i]) wire_bytes = {wire_bytes, payload[i]};
    crc = 16'h0000;
    foreach (wire_bytes[i]) crc = frame_checker::crc16_step(crc, wire_bytes[i]);
    if (spoil) crc ^= 16'h0001 << $urandom_range(15);
    wire_bytes = {wire_bytes, crc[7:0], crc[15:8]};
    for (int i = 0; i < wire_bytes.size() && i < keep; i++) begin
      send_byte(wire_bytes[i]);
    end
  endtask

  function automatic byte_q_t random_payload(int unsigned n);
    byte_q_t q;
    for (int i = 0; i < n; i++) q = {q, 8'($urandom)};
    return q;
  endfunction

  // Hold the input idle until every predicted beat is out, then let it settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (board.pending_beats.size() != 0) @(posedge clk_i);
    repeat (SettleBeats) @(posedge clk_i);
  endtask

  task automatic set_address(input logic [7:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.own_addr = value;
  endtask

  // Random traffic: mostly good frames, some noise, short lengths and cut frames
  task automatic run_random(input int unsigned goal);
    int unsigned start;
    int unsigned pick;
    int unsigned n;
    logic [7:0]  addr;
    byte_q_t     payload;
    start = bytes_sent;
    while (bytes_sent - start < goal) begin
      pick = $urandom_range(99);
      addr = ($urandom_range(3) != 0) ? board.own_addr : 8'($urandom);
      n    = $urandom_range(39);
      if (n == 0) begin
        payload = random_payload($urandom_range(13, 250));
      end else if (n < 8) begin
        case ($urandom_range(3))
          0:       payload = {CodeIllegal};
          1:       payload = {CodeNak};
          2:       payload = {CodeAck};
          default: payload = random_payload(1);
        endcase
      end else begin
        payload = random_payload($urandom_range(1, 12));
      end
      if (pick < 65) begin
        send_frame(addr, payload, $urandom_range(9) == 0, 32'hFFFF_FFFF);
      end else if (pick < 75) begin
        send_byte(SyncByte);
        send_byte(8'($urandom));
        send_byte(8'($urandom_range(0, 5)));
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        send_frame(addr, payload, 1'b0, $urandom_range(1, payload.size() + 6));
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= 8'h00;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    m_axis_tready <= 1'b0;
    board       = new();
    burst_left  = 0;
    bytes_sent  = 0;
    cycle_count = 0;
    mode_left   = 0;
    ready_mode  = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: stray bytes while waiting for sync
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h03);
    // Directed: total length below the minimum
    send_byte(SyncByte); send_byte(8'h03); send_byte(8'h00);
    send_byte(SyncByte); send_byte(8'hAA); send_byte(8'h05);
    // Directed: one-byte commands, a data frame, CRC and address errors
    send_frame(OwnAddrReset, {CodeIllegal}, 1'b0, 32'hFFFF_FFFF);
    send_frame(OwnAddrReset, {CodeNak}, 1'b0, 32'hFFFF_FFFF);
    send_frame(OwnAddrReset, {CodeAck}, 1'b0, 32'hFFFF_FFFF);
    send_frame(OwnAddrReset, {8'h55}, 1'b0, 32'hFFFF_FFFF);
    send_frame(OwnAddrReset, {CodeIllegal, CodeNak}, 1'b0, 32'hFFFF_FFFF);
    send_frame(OwnAddrReset, {8'hA5}, 1'b1, 32'hFFFF_FFFF);
    send_frame(8'hFF, {8'h01, 8'h80}, 1'b0, 32'hFFFF_FFFF);
    // Directed: longest payload the length byte allows
    send_frame(OwnAddrReset, random_payload(250), 1'b0, 32'hFFFF_FFFF);
    run_random(PhaseBytes);

    set_address(8'h00);
    send_frame(8'h00, {8'h7F}, 1'b0, 32'hFFFF_FFFF);
    run_random(PhaseBytes);

    set_address(8'hFF);
    send_frame(8'hFF, {8'hFE, 8'h00}, 1'b0, 32'hFFFF_FFFF);
    run_random(PhaseBytes);

    repeat (2) begin
      set_address(8'($urandom));
      run_random(PhaseBytes);
    end

    drain();
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
